>>> hdl/axis_position_selector_defines.svh
// ----------------------------------------------------------------------------
// axis_position_selector_defines
// Assertion macros shared by the position selector RTL.
// ----------------------------------------------------------------------------
`ifndef AXIS_POSITION_SELECTOR_DEFINES_SVH
`define AXIS_POSITION_SELECTOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define APS_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define APS_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error(msg);

// condition never holds
`define APS_ASSERT_NEVER(label, clk, rst, a, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error(msg);

`endif

>>> hdl/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// Types and codes shared by the axis position selector modules.
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int TBL_ADDR_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_WATCHED_AXIS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_POSITION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HELD_BUTTONS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OWNED_BUTTONS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_SELECTED    = 3'd6;

  localparam logic [1:0] MODE_AXIS  = 2'd0;
  localparam logic [1:0] MODE_APPLY = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [15:0] EV_ABS = 16'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] axis_value;
    logic [31:0]        joy_in;
    logic [4:0]         entry_index;
    logic signed [15:0] entry_value;
    logic [31:0]        entry_mask;
  } item_t;

  typedef struct packed {
    logic        handled;
    logic [31:0] joy_out;
    logic [4:0]  current_position_out;
  } result_t;

  typedef struct packed {
    logic [7:0]  watched_axis;
    logic [6:0]  match_tolerance;
    logic [4:0]  position_count;
    logic [4:0]  default_position;
    logic [31:0] held_buttons;
    logic [31:0] owned_buttons;
    logic        core_selected;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [31:0]        mask;
  } entry_t;

  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic [TBL_ADDR_W-1:0] addr;
    entry_t                wdata;
  } tbl_req_t;

endpackage

>>> hdl/aps_cfg.sv
// ----------------------------------------------------------------------------
// aps_cfg
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module aps_cfg import aps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WATCHED_AXIS:     regs.watched_axis     <= cfg_data[7:0];
        REG_MATCH_TOLERANCE:  regs.match_tolerance  <= cfg_data[6:0];
        REG_POSITION_COUNT:   regs.position_count   <= cfg_data[4:0];
        REG_DEFAULT_POSITION: regs.default_position <= cfg_data[4:0];
        REG_HELD_BUTTONS:     regs.held_buttons     <= cfg_data;
        REG_OWNED_BUTTONS:    regs.owned_buttons    <= cfg_data;
        REG_CORE_SELECTED:    regs.core_selected    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/aps_table.sv
// ----------------------------------------------------------------------------
// aps_table
// Position table: one-port synchronous memory with per-entry valid bits.
// ----------------------------------------------------------------------------
module aps_table import aps_pkg::*; #(
  parameter int MAX_POSITIONS = 24
) (
  input  logic     clk,
  input  logic     rst,
  input  tbl_req_t req,
  output entry_t   rd_data
);

  localparam int IDX_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

  entry_t                   mem [MAX_POSITIONS];
  logic [MAX_POSITIONS-1:0] valid;
  entry_t                   rd_q;
  logic                     rd_valid;
  logic [IDX_W-1:0]         idx;

  assign idx = req.addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[idx] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_q <= mem[idx];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[idx] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[idx];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

>>> hdl/aps_ctrl.sv
// ----------------------------------------------------------------------------
// aps_ctrl
// Sequencer: table scan for nearest position, apply, table write, result reg.
// ----------------------------------------------------------------------------
module aps_ctrl import aps_pkg::*; #(
  parameter int MAX_POSITIONS = 24
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     item_valid,
  output logic     item_stall,
  input  item_t    item,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result,
  output tbl_req_t tbl_req,
  input  entry_t   rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_AREAD = 3'd2;
  localparam logic [2:0] S_AUSE  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state;
  logic [4:0]         cur_pos;
  logic signed [31:0] reading;
  logic [31:0]        res_joy;
  logic               res_handled;
  logic [4:0]         wr_idx;
  entry_t             wr_entry;

  logic [4:0]  scan_idx;
  logic        issuing;
  logic        rd_pend;
  logic        rd_last;
  logic [4:0]  rd_idx;
  logic        dist_pend;
  logic        dist_last;
  logic [4:0]  dist_idx;
  logic [31:0] scan_d;
  logic        have_best;
  logic [4:0]  best_idx;
  logic [31:0] best_d;

  logic        accept;
  logic [2:0]  start_state;
  logic [4:0]  cnt;
  logic [4:0]  sel_pos;
  logic        apply_ok;
  logic        axis_hit;
  logic        write_ok;
  logic [32:0] diff;
  logic [32:0] mag;
  logic [31:0] dist_next;
  logic        take_new;
  logic [31:0] cand_d;
  logic [4:0]  cand_idx;
  logic        in_tol;
  logic        out_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign cnt = (32'(cfg.position_count) > 32'(MAX_POSITIONS)) ?
               5'(MAX_POSITIONS) : cfg.position_count;
  assign sel_pos  = (cur_pos != 5'd0) ? cur_pos : cfg.default_position;
  assign apply_ok = cfg.core_selected && (cnt != 5'd0) && (sel_pos != 5'd0) &&
                    (sel_pos <= cnt);
  assign axis_hit = (cnt != 5'd0) && (item.event_type == EV_ABS) &&
                    (item.event_code == {8'd0, cfg.watched_axis});
  assign write_ok = 32'(item.entry_index) < 32'(MAX_POSITIONS);

  // exact distance, computed in 33 bits and kept in 32 bits
  assign diff      = {reading[31], reading} - {{17{rd_data.value[15]}}, rd_data.value};
  assign mag       = diff[32] ? (33'd0 - diff) : diff;
  assign dist_next = mag[31:0];

  assign take_new = !have_best || (scan_d < best_d);
  assign cand_d   = take_new ? scan_d : best_d;
  assign cand_idx = take_new ? dist_idx : best_idx;
  assign in_tol   = cand_d <= 32'(cfg.match_tolerance);

  always_comb begin
    start_state = S_DONE;
    case (item.mode)
      MODE_AXIS: begin
        if (axis_hit) begin
          start_state = S_SCAN;
        end
      end
      MODE_APPLY: begin
        if (apply_ok) begin
          start_state = S_AREAD;
        end
      end
      MODE_WRITE: begin
        if (write_ok) begin
          start_state = S_WRITE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    tbl_req       = '0;
    tbl_req.wdata = wr_entry;
    case (state)
      S_SCAN: begin
        tbl_req.rd_en = issuing;
        tbl_req.addr  = TBL_ADDR_W'(scan_idx);
      end
      S_AREAD: begin
        tbl_req.rd_en = 1'b1;
        tbl_req.addr  = TBL_ADDR_W'(sel_pos - 5'd1);
      end
      S_WRITE: begin
        tbl_req.wr_en = 1'b1;
        tbl_req.addr  = TBL_ADDR_W'(wr_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_pos      <= 5'd0;
      issuing      <= 1'b0;
      rd_pend      <= 1'b0;
      dist_pend    <= 1'b0;
      have_best    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            reading     <= item.axis_value;
            res_joy     <= item.joy_in;
            res_handled <= (item.mode == MODE_AXIS) && axis_hit;
            wr_idx      <= item.entry_index;
            wr_entry    <= '{value: item.entry_value, mask: item.entry_mask};
            scan_idx    <= 5'd0;
            issuing     <= 1'b1;
            rd_pend     <= 1'b0;
            dist_pend   <= 1'b0;
            have_best   <= 1'b0;
            state       <= start_state;
          end
        end
        S_SCAN: begin
          rd_pend <= issuing;
          if (issuing) begin
            scan_idx <= scan_idx + 5'd1;
            rd_idx   <= scan_idx;
            rd_last  <= (scan_idx == cnt - 5'd1);
            if (scan_idx == cnt - 5'd1) begin
              issuing <= 1'b0;
            end
          end
          dist_pend <= rd_pend;
          scan_d    <= dist_next;
          dist_idx  <= rd_idx;
          dist_last <= rd_last;
          if (dist_pend) begin
            best_d    <= cand_d;
            best_idx  <= cand_idx;
            have_best <= 1'b1;
            if (dist_last) begin
              if (in_tol) begin
                cur_pos <= cand_idx + 5'd1;
              end
              state <= S_DONE;
            end
          end
        end
        S_AREAD: begin
          state <= S_AUSE;
        end
        S_AUSE: begin
          res_joy <= (res_joy & ~cfg.owned_buttons) | cfg.held_buttons | rd_data.mask;
          state   <= S_DONE;
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.handled              <= res_handled;
      result.joy_out              <= res_joy;
      result.current_position_out <= cur_pos;
    end
  end

endmodule

>>> hdl/axis_position_selector.sv
// ----------------------------------------------------------------------------
// axis_position_selector
// Axis event on watched axis: one table entry read per cycle; nearest entry within
// tolerance becomes current position. Apply with a position: one table read; table
// write: one write; other items go straight to done. A stalled result waits there.
// One item in flight; next item accepted once the result sits in the output reg.
// Sync reset clears config, FSM, current position; table reads zero until written.
// ----------------------------------------------------------------------------
`include "axis_position_selector_defines.svh"

module axis_position_selector import aps_pkg::*; #(
  parameter int MAX_POSITIONS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t     cfg_regs;
  tbl_req_t tbl_req;
  entry_t   rd_data;

  aps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg_regs)
  );

  aps_table #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  aps_ctrl #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_regs),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .tbl_req      (tbl_req),
    .rd_data      (rd_data)
  );

  `APS_ASSERT_NEXT(a_busy_after_transfer, clk, rst, item_valid && !item_stall, item_stall, "input not stalled after transfer")
  `APS_ASSERT_NEVER(a_table_port_excl, clk, rst, tbl_req.wr_en && tbl_req.rd_en, "table read and write in same cycle")
  `APS_ASSERT_IMPLY(a_position_range, clk, rst, result_valid, 32'(result.current_position_out) <= 32'(MAX_POSITIONS), "current position beyond table")

endmodule
